// File: rtl/udiv64_pkg.sv
// udiv64_pkg: shared types and constants for the unsigned divider
// request/response payloads, controller state, and controller/datapath command
// and status structs; no dependencies
package udiv64_pkg;

  localparam int DivWidth = 64;            // fixed width of the payload fields
  localparam int DataWidthDefault = 64;    // default working width

  typedef struct packed {
    logic [DivWidth-1:0] dividend;
    logic [DivWidth-1:0] divisor;
  } req_t;

  typedef struct packed {
    logic [DivWidth-1:0] quotient;
    logic [DivWidth-1:0] remainder;
    logic                divide_by_zero;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture a new request
    logic step;   // one shift-and-subtract step
    logic emit;   // move the finished result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic req_zero;  // divisor of the incoming request is zero
  } stat_t;

endpackage

// File: rtl/udiv64_ctrl.sv
// udiv64_ctrl: sequencer for the divider, counts the radix-2 steps and
// runs the request/response handshakes; depends on udiv64_pkg
module udiv64_ctrl #(
  parameter int DATA_WIDTH = udiv64_pkg::DataWidthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  input  udiv64_pkg::stat_t  stat,
  output udiv64_pkg::cmd_t   cmd
);
  import udiv64_pkg::*;

  localparam int CntW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(DATA_WIDTH - 1);

  state_t          state, state_next;
  logic [CntW-1:0] cnt;
  logic            slot_free;
  logic            last;

  assign slot_free = !rsp_valid || rsp_ready;
  assign last      = (cnt == LastCnt);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          // zero divisor needs no steps
          state_next = stat.req_zero ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    cmd       = '0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_RUN: begin
        cmd.step = 1'b1;
      end
      ST_FINISH: begin
        cmd.emit = slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) cnt <= '0;
      else if (cmd.step) cnt <= cnt + 1'b1;
      if (cmd.emit) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/udiv64_dpath.sv
// udiv64_dpath: restoring radix-2 division datapath with output register
// one quotient bit per step; depends on udiv64_pkg
module udiv64_dpath #(
  parameter int DATA_WIDTH = udiv64_pkg::DataWidthDefault
) (
  input  logic              clk,
  input  udiv64_pkg::req_t  req,
  input  udiv64_pkg::cmd_t  cmd,
  output udiv64_pkg::stat_t stat,
  output udiv64_pkg::rsp_t  rsp
);
  import udiv64_pkg::*;

  logic [DATA_WIDTH-1:0] rem, rem_next;
  logic [DATA_WIDTH-1:0] quo, quo_next;   // dividend shifts out the top, quotient in the bottom
  logic [DATA_WIDTH-1:0] dsr;
  logic                  dbz;
  logic [DATA_WIDTH-1:0] req_a;
  logic [DATA_WIDTH-1:0] req_b;
  logic [DATA_WIDTH:0]   diff;
  logic                  take;
  logic [DATA_WIDTH-1:0] q_out;
  logic [DATA_WIDTH-1:0] r_out;

  // bits above the working width are dropped
  assign req_a = req.dividend[DATA_WIDTH-1:0];
  assign req_b = req.divisor[DATA_WIDTH-1:0];
  assign stat.req_zero = (req_b == '0);

  // partial remainder is one bit wider than the divisor after the shift
  assign diff = {rem, quo[DATA_WIDTH-1]} - {1'b0, dsr};
  assign take = !diff[DATA_WIDTH];
  assign rem_next = take ? diff[DATA_WIDTH-1:0] : {rem[DATA_WIDTH-2:0], quo[DATA_WIDTH-1]};
  assign quo_next = {quo[DATA_WIDTH-2:0], take};

  // on zero divisor quo still holds the dividend
  assign q_out = dbz ? '1 : quo;
  assign r_out = dbz ? quo : rem;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem <= '0;
      quo <= req_a;
      dsr <= req_b;
      dbz <= (req_b == '0);
    end else if (cmd.step) begin
      rem <= rem_next;
      quo <= quo_next;
    end
    if (cmd.emit) begin
      rsp.quotient       <= DivWidth'(q_out);
      rsp.remainder      <= DivWidth'(r_out);
      rsp.divide_by_zero <= dbz;
    end
  end

endmodule

// File: rtl/unsigned_divider_64.sv
// Unsigned 64-bit divider returning quotient and remainder. A request is taken
// when the unit is idle; it then runs DATA_WIDTH restoring shift-and-subtract
// steps in one shared subtractor, one quotient bit per cycle, or none for a
// zero divisor. A zero divisor sets divide_by_zero and returns an all-ones
// quotient with the dividend as remainder. Input bits above DATA_WIDTH are
// ignored. The result sits in an output register, so a new request can be
// taken while the previous response waits for rsp_ready.
// Depends on udiv64_pkg, udiv64_ctrl and udiv64_dpath.
module unsigned_divider_64 #(
  parameter int DATA_WIDTH = udiv64_pkg::DataWidthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  udiv64_pkg::req_t req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output udiv64_pkg::rsp_t rsp
);
  import udiv64_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  udiv64_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  udiv64_dpath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dpath (
    .clk (clk),
    .req (req),
    .cmd (cmd),
    .stat(stat),
    .rsp (rsp)
  );

endmodule
